FILE: design/trackball_motion_mapper_assert.svh
// ----------------------------------------------------------------------------
// Trackball motion mapper assertion macros
// Concurrent checks on the block clock; they compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef TRACKBALL_MOTION_MAPPER_ASSERT_SVH
`define TRACKBALL_MOTION_MAPPER_ASSERT_SVH
`ifndef SYNTH
`define TMM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define TMM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TMM_ASSERT(lbl, prop, msg)
`define TMM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: design/tmm_pkg.sv
// ----------------------------------------------------------------------------
// Trackball motion mapper package
// Widths, codes, reset values and shared types of the motion mapper.
// ----------------------------------------------------------------------------
package tmm_pkg;

    localparam int MAX_TAPS_DEF = 32;

    localparam int DELTA_W   = 16;
    localparam int MODE_W    = 2;
    localparam int GAIN_W    = 10;
    localparam int BASE_W    = 8;
    localparam int STEP_W    = 8;
    localparam int ATHR_W    = 16;
    localparam int THR_W     = 12;
    localparam int MAG_W     = 17;
    localparam int KEY_W     = 3;
    localparam int MOVE_W    = 8;
    localparam int DIV_NUM_W = 25;
    localparam int DIV_DEN_W = 12;
    localparam int QUO_W     = 7;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [BASE_W-1:0]    BASE_GAIN_RST  = 8'd30;
    localparam logic [GAIN_W-1:0]    MAX_GAIN_RST   = 10'd200;
    localparam logic [STEP_W-1:0]    ACCEL_STEP_RST = 8'd4;
    localparam logic [ATHR_W-1:0]    ACCEL_THR_RST  = 16'd45;
    localparam logic [THR_W-1:0]     CARET_THR_RST  = 12'd24;
    localparam logic [THR_W-1:0]     SCROLL_THR_RST = 12'd50;
    localparam logic [DIV_DEN_W-1:0] CURSOR_DIVISOR = 12'd100;

    localparam logic [REG_IDX_W-1:0] REG_BASE_GAIN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_GAIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_STEP = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_THR  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CARET_THR  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SCROLL_THR = 3'd5;

    localparam logic [MODE_W-1:0] MODE_CURSOR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CARET  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCROLL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MEDIA  = 2'd3;

    localparam logic [KEY_W-1:0] KEY_RIGHT      = 3'd0;
    localparam logic [KEY_W-1:0] KEY_LEFT       = 3'd1;
    localparam logic [KEY_W-1:0] KEY_UP         = 3'd2;
    localparam logic [KEY_W-1:0] KEY_DOWN       = 3'd3;
    localparam logic [KEY_W-1:0] KEY_MEDIA_BASE = 3'd4;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_TAP    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN,
        S_MULX,
        S_DIVX_GO,
        S_DIVX_WAIT,
        S_MULY,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_ACCUM,
        S_EVAL,
        S_SCROLL_WAIT,
        S_TAP,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic                 kind;
        logic [KEY_W-1:0]     key_code;
        logic [MOVE_W-1:0]    move_x;
        logic [MOVE_W-1:0]    move_y;
        logic [MOVE_W-1:0]    scroll_h;
        logic [MOVE_W-1:0]    scroll_v;
        logic                 last;
    } t_result;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

FILE: design/tmm_div.sv
// ----------------------------------------------------------------------------
// Saturating serial divider
// Unsigned restoring divider, one quotient bit per cycle, quotient held to 127.
// ----------------------------------------------------------------------------
module tmm_div
    import tmm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(QUO_W + 1);
    localparam int PAD_W = DIV_NUM_W - DIV_DEN_W - QUO_W;

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [QUO_W-1:0]     r_bits;
    logic [QUO_W-1:0]     r_quo;

    logic [DIV_DEN_W:0]   w_trial;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_fit;
    logic                 w_sat;
    logic                 w_step;

    // A quotient at or above 128 saturates; below it the upper remainder is num >> 7.
    assign w_sat   = i_req.num >= {{PAD_W{1'b0}}, i_req.den, {QUO_W{1'b0}}};
    assign w_trial = {r_rem, r_bits[QUO_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_step  = r_busy && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= w_sat ? '0 : CNT_W'(QUO_W);
        end else if (w_step) begin
            r_cnt <= r_cnt - 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den  <= i_req.den;
            r_rem  <= i_req.num[QUO_W +: DIV_DEN_W];
            r_bits <= i_req.num[QUO_W-1:0];
            r_quo  <= w_sat ? '1 : '0;
        end else if (w_step) begin
            r_rem  <= w_fit ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
            r_bits <= {r_bits[QUO_W-2:0], 1'b0};
            r_quo  <= {r_quo[QUO_W-2:0], w_fit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.quo  = r_quo;

endmodule

FILE: design/trackball_motion_mapper.sv
// A cursor item runs gain update, X and Y multiply and divide, and the report; a scroll item
// accumulation, evaluation, a divide and the report; a caret or media item accumulation,
// evaluation, one tap item per tap and the report. A saturating quotient or a total below
// the scroll threshold shortens this, and output stalls lengthen it. One item at a time: the
// next is taken once the report loads, while that report may wait in the output register.
// Synchronous active-low reset restores the register defaults, base gain and accumulators.
// ----------------------------------------------------------------------------
// Trackball motion mapper
// Maps sensor deltas to cursor reports, scroll reports and runs of key taps.
// ----------------------------------------------------------------------------
`include "trackball_motion_mapper_assert.svh"

module trackball_motion_mapper
    import tmm_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [15:0] delta_x, [31:16] delta_y
    input  logic [31:0]         s_axis_tdata,
    // [1:0] mode_sel
    input  logic [MODE_W-1:0]   s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [2:0] key_code, [10:3] move_x, [18:11] move_y, [26:19] scroll_h,
    // [34:27] scroll_v, [39:35] zero
    output logic [39:0]         m_axis_tdata,
    // [0] kind
    output logic                m_axis_tuser,
    output logic                m_axis_tlast,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);

    function automatic logic [MOVE_W-1:0] apply_sign(input logic neg, input logic [QUO_W-1:0] q);
        logic [MOVE_W-1:0] mag;
        mag = {1'b0, q};
        return neg ? -mag : mag;
    endfunction

    function automatic logic [DELTA_W-1:0] sat_add(input logic [DELTA_W-1:0] a,
                                                   input logic [DELTA_W-1:0] b);
        logic [DELTA_W:0] sum;
        sum = {a[DELTA_W-1], a} + {b[DELTA_W-1], b};
        if (sum[DELTA_W] != sum[DELTA_W-1]) begin
            return sum[DELTA_W] ? {1'b1, {(DELTA_W-1){1'b0}}} : {1'b0, {(DELTA_W-1){1'b1}}};
        end
        return sum[DELTA_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic [DELTA_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {v[DELTA_W-1], v};
        return v[DELTA_W-1] ? -ext : ext;
    endfunction

    logic [BASE_W-1:0]  r_base_gain;
    logic [GAIN_W-1:0]  r_max_gain;
    logic [STEP_W-1:0]  r_accel_step;
    logic [ATHR_W-1:0]  r_accel_thr;
    logic [THR_W-1:0]   r_caret_thr;
    logic [THR_W-1:0]   r_scroll_thr;

    t_state               r_state, n_state;
    logic [GAIN_W-1:0]    r_gain, n_gain;
    logic [DELTA_W-1:0]   r_accum_x, n_accum_x;
    logic [DELTA_W-1:0]   r_accum_y, n_accum_y;
    logic [TAP_CNT_W-1:0] r_tap_cnt, n_tap_cnt;
    logic                 r_out_valid, n_out_valid;

    logic [DELTA_W-1:0]   r_dx, r_dy;
    logic [MODE_W-1:0]    r_mode;
    logic [DIV_NUM_W-1:0] r_prod;
    logic [MOVE_W-1:0]    r_mx, r_my, r_sh, r_sv;
    logic [KEY_W-1:0]     r_key;
    logic                 r_dom_x, r_neg;
    logic [MAG_W-1:0]     r_rem, r_dom_mag;
    t_result              r_out;

    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_in_acc;
    logic                 w_can_load;
    logic                 w_load_tap;
    logic                 w_load_rep;
    logic                 w_load_item;
    logic                 w_load_mul;
    logic                 w_load_scroll;
    logic                 w_rem_upd;
    logic                 w_tap_begin;
    logic [MAG_W-1:0]     w_mag_dx, w_mag_dy, w_ax, w_ay, w_total, w_mul_a;
    logic [MAG_W-1:0]     w_rem_next, w_dom_next;
    logic signed [MAG_W-1:0] w_dom_signed;
    logic [MAG_W+GAIN_W-1:0] w_prod;
    logic [MAG_W:0]       w_lhs, w_rhs;
    logic [GAIN_W:0]      w_gain_up;
    logic [GAIN_W-1:0]    w_gain_floor;
    logic [THR_W-1:0]     w_caret_t, w_scroll_t;
    logic                 w_x_dom;
    logic [TAP_CNT_W-1:0] w_cnt_next;
    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;

    tmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_gain  <= BASE_GAIN_RST;
            r_max_gain   <= MAX_GAIN_RST;
            r_accel_step <= ACCEL_STEP_RST;
            r_accel_thr  <= ACCEL_THR_RST;
            r_caret_thr  <= CARET_THR_RST;
            r_scroll_thr <= SCROLL_THR_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_BASE_GAIN:  r_base_gain  <= pwdata[BASE_W-1:0];
                REG_MAX_GAIN:   r_max_gain   <= pwdata[GAIN_W-1:0];
                REG_ACCEL_STEP: r_accel_step <= pwdata[STEP_W-1:0];
                REG_ACCEL_THR:  r_accel_thr  <= pwdata[ATHR_W-1:0];
                REG_CARET_THR:  r_caret_thr  <= pwdata[THR_W-1:0];
                REG_SCROLL_THR: r_scroll_thr <= pwdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_BASE_GAIN:  prdata = 32'(r_base_gain);
            REG_MAX_GAIN:   prdata = 32'(r_max_gain);
            REG_ACCEL_STEP: prdata = 32'(r_accel_step);
            REG_ACCEL_THR:  prdata = 32'(r_accel_thr);
            REG_CARET_THR:  prdata = 32'(r_caret_thr);
            REG_SCROLL_THR: prdata = 32'(r_scroll_thr);
            default:        prdata = '0;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_can_load    = !r_out_valid || m_axis_tready;

    assign w_caret_t  = (r_caret_thr == '0) ? THR_W'(1) : r_caret_thr;
    assign w_scroll_t = (r_scroll_thr == '0) ? THR_W'(1) : r_scroll_thr;

    assign w_mag_dx = mag_of(r_dx);
    assign w_mag_dy = mag_of(r_dy);
    assign w_ax     = mag_of(r_accum_x);
    assign w_ay     = mag_of(r_accum_y);
    assign w_total  = w_ax + w_ay;
    assign w_x_dom  = w_ax > w_ay;

    assign w_lhs        = (MAG_W+1)'(w_mag_dx + w_mag_dy) + (MAG_W+1)'(r_base_gain);
    assign w_rhs        = (MAG_W+1)'(r_accel_thr) + (MAG_W+1)'(r_gain);
    assign w_gain_up    = (GAIN_W+1)'(r_gain) + (GAIN_W+1)'(r_accel_step);
    assign w_gain_floor = GAIN_W'(r_base_gain) + GAIN_W'(r_accel_step);

    assign w_mul_a = (r_state == S_MULX) ? w_mag_dx : w_mag_dy;
    assign w_prod  = w_mul_a * r_gain;

    assign w_rem_next   = r_rem - MAG_W'(w_caret_t);
    assign w_dom_next   = (r_dom_mag > MAG_W'(w_caret_t)) ? r_dom_mag - MAG_W'(w_caret_t) : '0;
    assign w_dom_signed = r_neg ? -$signed(w_dom_next) : $signed(w_dom_next);
    assign w_cnt_next   = r_tap_cnt + 1'b1;

    always_comb begin
        n_state       = r_state;
        n_gain        = r_gain;
        n_accum_x     = r_accum_x;
        n_accum_y     = r_accum_y;
        n_tap_cnt     = r_tap_cnt;
        n_out_valid   = r_out_valid && !m_axis_tready;
        w_div_req     = '0;
        w_load_tap    = 1'b0;
        w_load_rep    = 1'b0;
        w_load_item   = 1'b0;
        w_load_mul    = 1'b0;
        w_load_scroll = 1'b0;
        w_rem_upd     = 1'b0;
        w_tap_begin   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_load_item = 1'b1;
                    n_state = (s_axis_tuser == MODE_CURSOR) ? S_GAIN : S_ACCUM;
                end
            end
            S_GAIN: begin
                if (w_lhs > w_rhs) begin
                    n_gain = (w_gain_up > (GAIN_W+1)'(r_max_gain)) ? r_max_gain
                                                                   : w_gain_up[GAIN_W-1:0];
                end else if (r_gain < w_gain_floor) begin
                    n_gain = GAIN_W'(r_base_gain);
                end else begin
                    n_gain = r_gain - GAIN_W'(r_accel_step);
                end
                n_state = S_MULX;
            end
            S_MULX: begin
                w_load_mul = 1'b1;
                n_state = S_DIVX_GO;
            end
            S_DIVX_GO: begin
                w_div_req = '{start: 1'b1, num: r_prod, den: CURSOR_DIVISOR};
                n_state = S_DIVX_WAIT;
            end
            S_DIVX_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = S_MULY;
                end
            end
            S_MULY: begin
                w_load_mul = 1'b1;
                n_state = S_DIVY_GO;
            end
            S_DIVY_GO: begin
                w_div_req = '{start: 1'b1, num: r_prod, den: CURSOR_DIVISOR};
                n_state = S_DIVY_WAIT;
            end
            S_DIVY_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = S_REPORT;
                end
            end
            S_ACCUM: begin
                n_accum_x = sat_add(r_accum_x, r_dx);
                n_accum_y = sat_add(r_accum_y, r_dy);
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_mode == MODE_SCROLL) begin
                    if (w_total >= MAG_W'(w_scroll_t)) begin
                        w_div_req = '{start: 1'b1, num: DIV_NUM_W'(w_total), den: w_scroll_t};
                        w_tap_begin = 1'b1;
                        n_state = S_SCROLL_WAIT;
                    end else begin
                        n_state = S_REPORT;
                    end
                end else if (w_total >= MAG_W'(w_caret_t)) begin
                    w_tap_begin = 1'b1;
                    n_tap_cnt = '0;
                    n_state = S_TAP;
                end else begin
                    n_state = S_REPORT;
                end
            end
            S_SCROLL_WAIT: begin
                if (w_div_rsp.done) begin
                    w_load_scroll = 1'b1;
                    n_accum_x = '0;
                    n_accum_y = '0;
                    n_state = S_REPORT;
                end
            end
            S_TAP: begin
                if (w_can_load) begin
                    w_load_tap  = 1'b1;
                    w_rem_upd   = 1'b1;
                    n_out_valid = 1'b1;
                    n_tap_cnt   = w_cnt_next;
                    if ((w_rem_next < MAG_W'(w_caret_t)) ||
                        (w_cnt_next >= TAP_CNT_W'(MAX_TAPS))) begin
                        if (r_dom_x) begin
                            n_accum_x = w_dom_signed[DELTA_W-1:0];
                            n_accum_y = '0;
                        end else begin
                            n_accum_x = '0;
                            n_accum_y = w_dom_signed[DELTA_W-1:0];
                        end
                        n_state = S_REPORT;
                    end
                end
            end
            S_REPORT: begin
                if (w_can_load) begin
                    w_load_rep  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= GAIN_W'(BASE_GAIN_RST);
            r_accum_x   <= '0;
            r_accum_y   <= '0;
            r_tap_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gain      <= n_gain;
            r_accum_x   <= n_accum_x;
            r_accum_y   <= n_accum_y;
            r_tap_cnt   <= n_tap_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_item) begin
            r_dx   <= s_axis_tdata[DELTA_W-1:0];
            r_dy   <= s_axis_tdata[2*DELTA_W-1:DELTA_W];
            r_mode <= s_axis_tuser;
            r_mx   <= '0;
            r_my   <= '0;
            r_sh   <= '0;
            r_sv   <= '0;
        end
        if (w_load_mul) begin
            r_prod <= w_prod[DIV_NUM_W-1:0];
        end
        if ((r_state == S_DIVX_WAIT) && w_div_rsp.done) begin
            r_mx <= apply_sign(r_dx[DELTA_W-1], w_div_rsp.quo);
        end
        if ((r_state == S_DIVY_WAIT) && w_div_rsp.done) begin
            r_my <= apply_sign(!r_dy[DELTA_W-1], w_div_rsp.quo);
        end
        if (w_load_scroll) begin
            if (r_dom_x) begin
                r_sh <= apply_sign(r_neg, w_div_rsp.quo);
            end else begin
                r_sv <= apply_sign(r_neg, w_div_rsp.quo);
            end
        end
        if (w_tap_begin) begin
            r_dom_x   <= w_x_dom;
            r_neg     <= w_x_dom ? r_accum_x[DELTA_W-1] : r_accum_y[DELTA_W-1];
            r_rem     <= w_total;
            r_dom_mag <= w_x_dom ? w_ax : w_ay;
            r_key     <= ((r_mode == MODE_MEDIA) ? KEY_MEDIA_BASE : KEY_RIGHT) +
                         (w_x_dom ? (r_accum_x[DELTA_W-1] ? KEY_LEFT : KEY_RIGHT)
                                  : (r_accum_y[DELTA_W-1] ? KEY_DOWN : KEY_UP));
        end
        if (w_rem_upd) begin
            r_rem     <= w_rem_next;
            r_dom_mag <= w_dom_next;
        end
        if (w_load_tap) begin
            r_out <= '{kind: KIND_TAP, key_code: r_key, move_x: '0, move_y: '0,
                       scroll_h: '0, scroll_v: '0, last: 1'b0};
        end else if (w_load_rep) begin
            r_out <= '{kind: KIND_REPORT, key_code: KEY_RIGHT, move_x: r_mx, move_y: r_my,
                       scroll_h: r_sh, scroll_v: r_sv, last: 1'b1};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.scroll_v, r_out.scroll_h, r_out.move_y,
                            r_out.move_x, r_out.key_code};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

    `TMM_ASSERT(a_tap_not_last, (m_axis_tvalid && (m_axis_tuser == KIND_TAP)) |-> !m_axis_tlast, "tap item marked last")
    `TMM_ASSERT(a_div_start_idle, w_div_req.start |-> !w_div_rsp.busy, "divider restarted while busy")
    `TMM_ASSERT(a_tap_cnt_range, r_tap_cnt <= TAP_CNT_W'(MAX_TAPS), "tap count beyond limit")
    `TMM_ASSERT(a_accept_busy, (s_axis_tvalid && s_axis_tready) |=> (r_state != S_IDLE), "item accepted without leaving idle")
    `TMM_ASSERT_RST(a_rst_out_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule
